// ----- hw/rtl/lcdnib_pkg.sv -----
// Shared constants and types for the character LCD nibble bus sequencer.
package lcdnib_pkg;

    localparam int COUNTER_BITS_DEF = 20;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 20;
    localparam int DUR_W            = 20;

    // operation codes carried in tuser
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_CMD  = 2'd1;
    localparam logic [1:0] OP_DATA = 2'd2;
    localparam logic [1:0] OP_INIT = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_USE_BUSY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STROBE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP   = 3'd5;

    // configuration reset values
    localparam logic [7:0]  STROBE_DEF   = 8'd2;
    localparam logic [15:0] SETTLE_DEF   = 16'd120;
    localparam logic [15:0] SHORT_DEF    = 16'd5000;
    localparam logic [15:0] MODE_DEF     = 16'd100;
    localparam logic [19:0] POWER_UP_DEF = 20'd100000;

    // sequencer phases
    localparam int PH_W = 4;
    localparam logic [PH_W-1:0] PH_IDLE      = 4'd0;
    localparam logic [PH_W-1:0] PH_PWR       = 4'd1;
    localparam logic [PH_W-1:0] PH_RST_HI    = 4'd2;
    localparam logic [PH_W-1:0] PH_RST_LO    = 4'd3;
    localparam logic [PH_W-1:0] PH_MODE_HI   = 4'd4;
    localparam logic [PH_W-1:0] PH_MODE_LO   = 4'd5;
    localparam logic [PH_W-1:0] PH_W_HI      = 4'd6;
    localparam logic [PH_W-1:0] PH_W_GAP     = 4'd7;
    localparam logic [PH_W-1:0] PH_W_LO      = 4'd8;
    localparam logic [PH_W-1:0] PH_SETTLE    = 4'd9;
    localparam logic [PH_W-1:0] PH_R_HI      = 4'd10;
    localparam logic [PH_W-1:0] PH_R_GAP     = 4'd11;
    localparam logic [PH_W-1:0] PH_R_LO      = 4'd12;
    localparam logic [PH_W-1:0] PH_R_END     = 4'd13;
    localparam logic [PH_W-1:0] PH_CLR_PAUSE = 4'd14;

    localparam logic [2:0] INIT_LAST   = 3'd5;
    localparam logic [2:0] INIT_CLEAR  = 3'd3;
    localparam logic [1:0] RST_REPEATS = 2'd2;

    localparam logic [3:0] NIB_RESET = 4'h3;
    localparam logic [3:0] NIB_MODE4 = 4'h2;

    typedef struct packed {
        logic [7:0] status_byte;
        logic       rejected;
        logic       ready_res;
        logic       drive_pins;
        logic [3:0] nibble_out;
        logic       enable_line;
        logic       read_write;
        logic       reg_select;
    } t_result;

    // init command bytes, indexed from 0
    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h28;
            3'd1:    b = 8'h08;
            3'd2:    b = 8'h01;
            3'd3:    b = 8'h06;
            3'd4:    b = 8'h0C;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- hw/rtl/char_lcd_nibble_bus_sequencer.sv -----
// Top level: 4-bit character LCD bus sequencer with init, write and busy polling.
//
// Input stream: one transaction per timebase tick. tuser carries the operation
// (tick, command write, data write, run init); tdata carries the byte to write
// and the D7..D4 levels sampled this tick. Output stream: one transaction per
// input transaction with the bus line levels after that tick, the ready and
// rejected flags and the last status byte read.
// Configuration writes go through the cfg channel, which is always ready; they
// are to be made while no tick is in flight.
// A result is registered and appears in the cycle after its input is taken.
// One tick per cycle when not stalled; the output register is the only stage.
// When the receiver stalls, the output register holds and the input is taken
// again in the same cycle the pending result is consumed.
// Reset (synchronous, active low) returns the sequencer to idle, not
// initialized, all bus lines low, and loads the configuration defaults.
module char_lcd_nibble_bus_sequencer #(
    parameter int COUNTER_BITS = lcdnib_pkg::COUNTER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [7:0] byte_value, [11:8] pins_sampled
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] reg_select, [1] read_write, [2] enable_line, [6:3] nibble_out,
    // [7] drive_pins, [8] ready_res, [9] rejected, [17:10] status_byte
    output logic [23:0] o_m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [lcdnib_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lcdnib_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int WIDE = (COUNTER_BITS > lcdnib_pkg::DUR_W) ? COUNTER_BITS
                                                              : lcdnib_pkg::DUR_W;
    localparam logic [WIDE-1:0] CNT_MAX = WIDE'((33'd1 << COUNTER_BITS) - 33'd1);

    function automatic logic [COUNTER_BITS-1:0] dur_load(
        input logic [lcdnib_pkg::DUR_W-1:0] dur
    );
        logic [WIDE-1:0] m1;
        m1 = WIDE'(dur) - WIDE'(1);
        if (dur == '0) begin
            return '0;
        end
        return COUNTER_BITS'((m1 > CNT_MAX) ? CNT_MAX : m1);
    endfunction

    // configuration
    logic        r_use_busy;
    logic [7:0]  r_strobe;
    logic [15:0] r_settle;
    logic [15:0] r_short;
    logic [15:0] r_mode;
    logic [19:0] r_power_up;

    // sequencer state
    logic [lcdnib_pkg::PH_W-1:0] r_phase, n_phase;
    logic [COUNTER_BITS-1:0]     r_tick, n_tick;
    logic [7:0]                  r_held_byte, n_held_byte;
    logic                        r_held_sel, n_held_sel;
    logic [2:0]                  r_init_idx, n_init_idx;
    logic [1:0]                  r_rep, n_rep;
    logic [7:0]                  r_last_status, n_last_status;
    logic                        r_rs, n_rs;
    logic                        r_rw, n_rw;
    logic                        r_e, n_e;
    logic [3:0]                  r_nib, n_nib;
    logic                        r_drive, n_drive;

    logic                  r_out_valid;
    lcdnib_pkg::t_result   r_out;
    lcdnib_pkg::t_result   n_out;

    logic       s_accept;
    logic [1:0] op;
    logic [7:0] in_byte;
    logic [3:0] pins;
    logic       rej;
    logic       do_fin, do_next, do_read, do_sb;
    logic [7:0] sb_val;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign op              = i_s_axis_tuser;
    assign in_byte         = i_s_axis_tdata[7:0];
    assign pins            = i_s_axis_tdata[11:8];
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_busy <= 1'b0;
            r_strobe   <= lcdnib_pkg::STROBE_DEF;
            r_settle   <= lcdnib_pkg::SETTLE_DEF;
            r_short    <= lcdnib_pkg::SHORT_DEF;
            r_mode     <= lcdnib_pkg::MODE_DEF;
            r_power_up <= lcdnib_pkg::POWER_UP_DEF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lcdnib_pkg::CFG_USE_BUSY: r_use_busy <= i_cfg_data[0];
                lcdnib_pkg::CFG_STROBE:   r_strobe   <= i_cfg_data[7:0];
                lcdnib_pkg::CFG_SETTLE:   r_settle   <= i_cfg_data[15:0];
                lcdnib_pkg::CFG_SHORT:    r_short    <= i_cfg_data[15:0];
                lcdnib_pkg::CFG_MODE:     r_mode     <= i_cfg_data[15:0];
                lcdnib_pkg::CFG_POWER_UP: r_power_up <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_tick        = r_tick;
        n_held_byte   = r_held_byte;
        n_held_sel    = r_held_sel;
        n_init_idx    = r_init_idx;
        n_rep         = r_rep;
        n_last_status = r_last_status;
        n_rs          = r_rs;
        n_rw          = r_rw;
        n_e           = r_e;
        n_nib         = r_nib;
        n_drive       = r_drive;
        rej           = 1'b0;
        do_fin        = 1'b0;
        do_next       = 1'b0;
        do_read       = 1'b0;
        do_sb         = 1'b0;
        sb_val        = 8'h00;

        if (r_phase == lcdnib_pkg::PH_IDLE) begin
            if (op == lcdnib_pkg::OP_CMD || op == lcdnib_pkg::OP_DATA) begin
                n_held_sel = (op == lcdnib_pkg::OP_DATA);
                n_init_idx = '0;
                do_sb      = 1'b1;
                sb_val     = in_byte;
            end else if (op == lcdnib_pkg::OP_INIT) begin
                n_init_idx = '0;
                n_rs       = 1'b0;
                n_rw       = 1'b0;
                n_e        = 1'b0;
                n_nib      = 4'h0;
                n_drive    = 1'b1;
                n_phase    = lcdnib_pkg::PH_PWR;
                n_tick     = dur_load(r_power_up);
            end
        end else begin
            rej = (op != lcdnib_pkg::OP_TICK);
            if (r_tick != '0) begin
                n_tick = r_tick - COUNTER_BITS'(1);
            end else begin
                unique case (r_phase)
                    lcdnib_pkg::PH_PWR: begin
                        n_rep   = '0;
                        n_nib   = lcdnib_pkg::NIB_RESET;
                        n_e     = 1'b1;
                        n_phase = lcdnib_pkg::PH_RST_HI;
                        n_tick  = dur_load(20'(r_strobe));
                    end
                    lcdnib_pkg::PH_RST_HI: begin
                        n_e     = 1'b0;
                        n_phase = lcdnib_pkg::PH_RST_LO;
                        n_tick  = dur_load(20'(r_short));
                    end
                    lcdnib_pkg::PH_RST_LO: begin
                        n_e = 1'b1;
                        if (r_rep < lcdnib_pkg::RST_REPEATS) begin
                            n_rep   = r_rep + 2'd1;
                            n_phase = lcdnib_pkg::PH_RST_HI;
                        end else begin
                            n_nib   = lcdnib_pkg::NIB_MODE4;
                            n_phase = lcdnib_pkg::PH_MODE_HI;
                        end
                        n_tick = dur_load(20'(r_strobe));
                    end
                    lcdnib_pkg::PH_MODE_HI: begin
                        n_e     = 1'b0;
                        n_phase = lcdnib_pkg::PH_MODE_LO;
                        n_tick  = dur_load(20'(r_mode));
                    end
                    lcdnib_pkg::PH_MODE_LO: begin
                        n_init_idx = 3'd1;
                        n_held_sel = 1'b0;
                        do_sb      = 1'b1;
                        sb_val     = lcdnib_pkg::init_byte(3'd0);
                    end
                    lcdnib_pkg::PH_W_HI: begin
                        n_e     = 1'b0;
                        n_phase = lcdnib_pkg::PH_W_GAP;
                        n_tick  = dur_load(20'(r_strobe));
                    end
                    lcdnib_pkg::PH_W_GAP: begin
                        n_nib   = r_held_byte[3:0];
                        n_e     = 1'b1;
                        n_phase = lcdnib_pkg::PH_W_LO;
                        n_tick  = dur_load(20'(r_strobe));
                    end
                    lcdnib_pkg::PH_W_LO: begin
                        if (r_use_busy) begin
                            do_read = 1'b1;
                        end else begin
                            n_e     = 1'b0;
                            n_phase = lcdnib_pkg::PH_SETTLE;
                            n_tick  = dur_load(20'(r_settle));
                        end
                    end
                    lcdnib_pkg::PH_SETTLE: begin
                        do_fin = 1'b1;
                    end
                    lcdnib_pkg::PH_R_HI: begin
                        n_held_byte = {pins, 4'h0};
                        n_e         = 1'b0;
                        n_phase     = lcdnib_pkg::PH_R_GAP;
                        n_tick      = dur_load(20'(r_strobe));
                    end
                    lcdnib_pkg::PH_R_GAP: begin
                        n_e     = 1'b1;
                        n_phase = lcdnib_pkg::PH_R_LO;
                        n_tick  = dur_load(20'(r_strobe));
                    end
                    lcdnib_pkg::PH_R_LO: begin
                        n_last_status = {r_held_byte[7:4], pins};
                        n_e           = 1'b0;
                        n_phase       = lcdnib_pkg::PH_R_END;
                        n_tick        = dur_load(20'(r_strobe));
                    end
                    lcdnib_pkg::PH_R_END: begin
                        if (r_last_status[7]) begin
                            do_read = 1'b1;
                        end else begin
                            do_fin = 1'b1;
                        end
                    end
                    lcdnib_pkg::PH_CLR_PAUSE: begin
                        do_next = 1'b1;
                    end
                    default: begin
                        n_phase = lcdnib_pkg::PH_IDLE;
                        n_tick  = '0;
                        n_e     = 1'b0;
                    end
                endcase
            end
        end

        if (do_fin) begin
            n_e = 1'b0;
            if (r_init_idx == lcdnib_pkg::INIT_CLEAR) begin
                n_phase = lcdnib_pkg::PH_CLR_PAUSE;
                n_tick  = dur_load(20'(r_short));
            end else begin
                do_next = 1'b1;
            end
        end

        if (do_next) begin
            if (r_init_idx >= 3'd1 && r_init_idx < lcdnib_pkg::INIT_LAST) begin
                n_init_idx = r_init_idx + 3'd1;
                n_held_sel = 1'b0;
                do_sb      = 1'b1;
                sb_val     = lcdnib_pkg::init_byte(r_init_idx);
            end else begin
                n_init_idx = '0;
                n_e        = 1'b0;
                n_phase    = lcdnib_pkg::PH_IDLE;
                n_tick     = '0;
            end
        end

        if (do_read) begin
            n_rs    = 1'b0;
            n_rw    = 1'b1;
            n_drive = 1'b0;
            n_nib   = 4'h0;
            n_e     = 1'b1;
            n_phase = lcdnib_pkg::PH_R_HI;
            n_tick  = dur_load(20'(r_strobe));
        end

        if (do_sb) begin
            n_held_byte = sb_val;
            n_rs        = n_held_sel;
            n_rw        = 1'b0;
            n_drive     = 1'b1;
            n_nib       = sb_val[7:4];
            n_e         = 1'b1;
            n_phase     = lcdnib_pkg::PH_W_HI;
            n_tick      = dur_load(20'(r_strobe));
        end

        n_out.reg_select  = n_rs;
        n_out.read_write  = n_rw;
        n_out.enable_line = n_e;
        n_out.nibble_out  = n_nib;
        n_out.drive_pins  = n_drive;
        n_out.ready_res   = (n_phase == lcdnib_pkg::PH_IDLE);
        n_out.rejected    = rej;
        n_out.status_byte = n_last_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= lcdnib_pkg::PH_IDLE;
            r_tick        <= '0;
            r_held_byte   <= '0;
            r_held_sel    <= 1'b0;
            r_init_idx    <= '0;
            r_rep         <= '0;
            r_last_status <= '0;
            r_rs          <= 1'b0;
            r_rw          <= 1'b0;
            r_e           <= 1'b0;
            r_nib         <= '0;
            r_drive       <= 1'b0;
        end else if (s_accept) begin
            r_phase       <= n_phase;
            r_tick        <= n_tick;
            r_held_byte   <= n_held_byte;
            r_held_sel    <= n_held_sel;
            r_init_idx    <= n_init_idx;
            r_rep         <= n_rep;
            r_last_status <= n_last_status;
            r_rs          <= n_rs;
            r_rw          <= n_rw;
            r_e           <= n_e;
            r_nib         <= n_nib;
            r_drive       <= n_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out <= n_out;
        end
    end

    a_idle_enable_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == lcdnib_pkg::PH_IDLE) |-> !r_e)
        else $error("enable high while idle");

    a_read_bus_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == lcdnib_pkg::PH_R_HI || r_phase == lcdnib_pkg::PH_R_GAP ||
         r_phase == lcdnib_pkg::PH_R_LO || r_phase == lcdnib_pkg::PH_R_END)
        |-> (!r_drive && r_rw && !r_rs))
        else $error("data pins driven during status read");

    a_init_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_init_idx <= lcdnib_pkg::INIT_LAST) && (r_rep <= lcdnib_pkg::RST_REPEATS))
        else $error("init counters out of range");

    a_init_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_init_idx != 3'd0) |-> (r_phase != lcdnib_pkg::PH_IDLE))
        else $error("init byte pending while idle");

    a_ready_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_out.ready_res == (r_phase == lcdnib_pkg::PH_IDLE)))
        else $error("ready flag does not match phase");

endmodule

// ----- tb/sv/tb_char_lcd_nibble_bus_sequencer.sv -----
// Testbench for the LCD nibble bus sequencer: directed table, then random ticks vs a bus model.
`timescale 1ns / 100ps

module tb_char_lcd_nibble_bus_sequencer;
    import lcdnib_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [15:0]           s_data = '0;
    logic [1:0]            s_user = OP_TICK;
    logic                  m_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_ready;
    logic                  m_valid;
    logic [23:0]           m_data;
    logic                  cfg_ready;

    int src_idle = 27;
    int dst_idle = 82;
    int mismatches = 0;

    t_result bus_levels_q [$];

    // shadow of the configuration registers
    logic        c_busy = 1'b0;
    logic [7:0]  c_strobe = STROBE_DEF;
    logic [15:0] c_settle = SETTLE_DEF;
    logic [15:0] c_short = SHORT_DEF;
    logic [15:0] c_mode = MODE_DEF;
    logic [19:0] c_power = POWER_UP_DEF;

    // bus model state
    logic [PH_W-1:0] ph = PH_IDLE;
    logic [19:0]     cnt = '0;
    logic [7:0]      hold_b = '0;
    logic            hold_rs = 1'b0;
    logic [2:0]      init_idx = '0;
    logic [1:0]      rst_rep = '0;
    logic [7:0]      status = '0;
    logic            l_rs = 1'b0;
    logic            l_rw = 1'b0;
    logic            l_e = 1'b0;
    logic [3:0]      l_nib = '0;
    logic            l_drive = 1'b0;

    localparam logic [7:0] INIT_SEQ [5] = '{8'h28, 8'h08, 8'h01, 8'h06, 8'h0C};

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [1:0]            op;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        logic [3:0]            pins;
        logic                  run_out;
        logic                  has_want;
        t_result               want;
    } t_dir_row;

    localparam int N_DIR = 32;

    // want: status, rejected, ready, drive, nibble, enable, rw, rs
    t_dir_row dir_tab [N_DIR] = '{
        '{ROW_ITEM, OP_TICK, CFG_USE_BUSY, 20'hFF, 4'hF, 1'b0, 1'b1,
          '{8'h00, 1'b0, 1'b1, 1'b0, 4'h0, 1'b0, 1'b0, 1'b0}},
        '{ROW_ITEM, OP_CMD, CFG_USE_BUSY, 20'hFF, 4'h0, 1'b0, 1'b1,
          '{8'h00, 1'b0, 1'b0, 1'b1, 4'hF, 1'b1, 1'b0, 1'b0}},
        '{ROW_ITEM, OP_DATA, CFG_USE_BUSY, 20'h00, 4'h0, 1'b0, 1'b1,
          '{8'h00, 1'b1, 1'b0, 1'b1, 4'hF, 1'b1, 1'b0, 1'b0}},
        '{ROW_ITEM, OP_INIT, CFG_USE_BUSY, 20'h00, 4'h0, 1'b1, 1'b1,
          '{8'h00, 1'b1, 1'b0, 1'b1, 4'hF, 1'b0, 1'b0, 1'b0}},
        '{ROW_REG, OP_TICK, CFG_STROBE, 20'd1, 4'h0, 1'b0, 1'b0, '0},
        '{ROW_REG, OP_TICK, CFG_SETTLE, 20'd1, 4'h0, 1'b0, 1'b0, '0},
        '{ROW_REG, OP_TICK, CFG_SHORT, 20'd1, 4'h0, 1'b0, 1'b0, '0},
        '{ROW_REG, OP_TICK, CFG_MODE, 20'd1, 4'h0, 1'b0, 1'b0, '0},
        '{ROW_REG, OP_TICK, CFG_POWER_UP, 20'd1, 4'h0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, OP_DATA, CFG_USE_BUSY, 20'h00, 4'h0, 1'b1, 1'b1,
          '{8'h00, 1'b0, 1'b0, 1'b1, 4'h0, 1'b1, 1'b0, 1'b1}},
        '{ROW_ITEM, OP_INIT, CFG_USE_BUSY, 20'hFF, 4'hF, 1'b1, 1'b1,
          '{8'h00, 1'b0, 1'b0, 1'b1, 4'h0, 1'b0, 1'b0, 1'b0}},
        '{ROW_REG, OP_TICK, CFG_USE_BUSY, 20'd1, 4'h0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, OP_CMD, CFG_USE_BUSY, 20'h5A, 4'hF, 1'b1, 1'b0, '0},
        '{ROW_ITEM, OP_DATA, CFG_USE_BUSY, 20'hFF, 4'h0, 1'b1, 1'b0, '0},
        '{ROW_ITEM, OP_INIT, CFG_USE_BUSY, 20'h00, 4'hF, 1'b1, 1'b0, '0},
        '{ROW_REG, OP_TICK, CFG_STROBE, 20'd0, 4'h0, 1'b0, 1'b0, '0},
        '{ROW_REG, OP_TICK, CFG_SETTLE, 20'd0, 4'h0, 1'b0, 1'b0, '0},
        '{ROW_REG, OP_TICK, CFG_SHORT, 20'd0, 4'h0, 1'b0, 1'b0, '0},
        '{ROW_REG, OP_TICK, CFG_MODE, 20'd0, 4'h0, 1'b0, 1'b0, '0},
        '{ROW_REG, OP_TICK, CFG_POWER_UP, 20'd0, 4'h0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, OP_INIT, CFG_USE_BUSY, 20'h00, 4'h0, 1'b1, 1'b0, '0},
        '{ROW_REG, OP_TICK, CFG_USE_BUSY, 20'd0, 4'h0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, OP_CMD, CFG_USE_BUSY, 20'h81, 4'h0, 1'b1, 1'b0, '0},
        '{ROW_REG, OP_TICK, CFG_STROBE, 20'd6, 4'h0, 1'b0, 1'b0, '0},
        '{ROW_REG, OP_TICK, CFG_USE_BUSY, 20'd1, 4'h0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, OP_DATA, CFG_USE_BUSY, 20'h3C, 4'hF, 1'b1, 1'b0, '0},
        '{ROW_REG, OP_TICK, CFG_USE_BUSY, 20'd0, 4'h0, 1'b0, 1'b0, '0},
        '{ROW_REG, OP_TICK, CFG_SETTLE, 20'd40, 4'h0, 1'b0, 1'b0, '0},
        '{ROW_REG, OP_TICK, CFG_SHORT, 20'd30, 4'h0, 1'b0, 1'b0, '0},
        '{ROW_REG, OP_TICK, CFG_MODE, 20'd25, 4'h0, 1'b0, 1'b0, '0},
        '{ROW_REG, OP_TICK, CFG_POWER_UP, 20'd60, 4'h0, 1'b0, 1'b0, '0},
        '{ROW_ITEM, OP_CMD, CFG_USE_BUSY, 20'h7E, 4'hA, 1'b1, 1'b0, '0}
    };

    char_lcd_nibble_bus_sequencer dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    always @(negedge clk) begin
        m_ready <= ($urandom_range(99) >= dst_idle);
    end

    function automatic void load_timer(input logic [PH_W-1:0] nxt, input logic [19:0] dur);
        ph = nxt;
        cnt = (dur == '0) ? '0 : dur - 20'd1;
    endfunction

    function automatic void begin_byte(input logic [7:0] b);
        hold_b = b;
        l_rs = hold_rs;
        l_rw = 1'b0;
        l_drive = 1'b1;
        l_nib = b[7:4];
        l_e = 1'b1;
        load_timer(PH_W_HI, 20'(c_strobe));
    endfunction

    function automatic void advance_init();
        if (init_idx >= 3'd1 && init_idx < INIT_LAST) begin
            init_idx = init_idx + 3'd1;
            hold_rs = 1'b0;
            begin_byte(INIT_SEQ[int'(init_idx) - 1]);
        end else begin
            init_idx = '0;
            l_e = 1'b0;
            ph = PH_IDLE;
            cnt = '0;
        end
    endfunction

    function automatic void byte_done();
        l_e = 1'b0;
        if (init_idx == INIT_CLEAR) begin
            load_timer(PH_CLR_PAUSE, 20'(c_short));
        end else begin
            advance_init();
        end
    endfunction

    function automatic void begin_read();
        l_rs = 1'b0;
        l_rw = 1'b1;
        l_drive = 1'b0;
        l_nib = '0;
        l_e = 1'b1;
        load_timer(PH_R_HI, 20'(c_strobe));
    endfunction

    function automatic void phase_done(input logic [3:0] pins);
        case (ph)
            PH_PWR: begin
                rst_rep = '0;
                l_nib = NIB_RESET;
                l_e = 1'b1;
                load_timer(PH_RST_HI, 20'(c_strobe));
            end
            PH_RST_HI: begin
                l_e = 1'b0;
                load_timer(PH_RST_LO, 20'(c_short));
            end
            PH_RST_LO: begin
                l_e = 1'b1;
                if (rst_rep < RST_REPEATS) begin
                    rst_rep = rst_rep + 2'd1;
                    load_timer(PH_RST_HI, 20'(c_strobe));
                end else begin
                    l_nib = NIB_MODE4;
                    load_timer(PH_MODE_HI, 20'(c_strobe));
                end
            end
            PH_MODE_HI: begin
                l_e = 1'b0;
                load_timer(PH_MODE_LO, 20'(c_mode));
            end
            PH_MODE_LO: begin
                init_idx = 3'd1;
                hold_rs = 1'b0;
                begin_byte(INIT_SEQ[0]);
            end
            PH_W_HI: begin
                l_e = 1'b0;
                load_timer(PH_W_GAP, 20'(c_strobe));
            end
            PH_W_GAP: begin
                l_nib = hold_b[3:0];
                l_e = 1'b1;
                load_timer(PH_W_LO, 20'(c_strobe));
            end
            PH_W_LO: begin
                if (c_busy) begin
                    begin_read();
                end else begin
                    l_e = 1'b0;
                    load_timer(PH_SETTLE, 20'(c_settle));
                end
            end
            PH_SETTLE: byte_done();
            PH_R_HI: begin
                hold_b = {pins, 4'h0};
                l_e = 1'b0;
                load_timer(PH_R_GAP, 20'(c_strobe));
            end
            PH_R_GAP: begin
                l_e = 1'b1;
                load_timer(PH_R_LO, 20'(c_strobe));
            end
            PH_R_LO: begin
                status = {hold_b[7:4], pins};
                l_e = 1'b0;
                load_timer(PH_R_END, 20'(c_strobe));
            end
            PH_R_END: begin
                if (status[7]) begin
                    begin_read();
                end else begin
                    byte_done();
                end
            end
            PH_CLR_PAUSE: advance_init();
            default: begin
                ph = PH_IDLE;
                cnt = '0;
                l_e = 1'b0;
            end
        endcase
    endfunction

    function automatic t_result lcd_bus_after_tick(input logic [1:0] op, input logic [7:0] b,
                                                   input logic [3:0] pins);
        t_result r;
        logic    rej;
        rej = 1'b0;
        if (ph == PH_IDLE) begin
            if (op == OP_CMD || op == OP_DATA) begin
                hold_rs = (op == OP_DATA);
                init_idx = '0;
                begin_byte(b);
            end else if (op == OP_INIT) begin
                init_idx = '0;
                l_rs = 1'b0;
                l_rw = 1'b0;
                l_e = 1'b0;
                l_nib = '0;
                l_drive = 1'b1;
                load_timer(PH_PWR, c_power);
            end
        end else begin
            rej = (op != OP_TICK);
            if (cnt != '0) begin
                cnt = cnt - 20'd1;
            end else begin
                phase_done(pins);
            end
        end
        r.reg_select = l_rs;
        r.read_write = l_rw;
        r.enable_line = l_e;
        r.nibble_out = l_nib;
        r.drive_pins = l_drive;
        r.ready_res = (ph == PH_IDLE);
        r.rejected = rej;
        r.status_byte = status;
        return r;
    endfunction

    function automatic void shadow_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                             input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_USE_BUSY: c_busy = val[0];
            CFG_STROBE:   c_strobe = val[7:0];
            CFG_SETTLE:   c_settle = val[15:0];
            CFG_SHORT:    c_short = val[15:0];
            CFG_MODE:     c_mode = val[15:0];
            CFG_POWER_UP: c_power = val[19:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb: mismatch %s got %0h want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_tick(input logic [1:0] op, input logic [7:0] b, input logic [3:0] pins,
                             input logic has_want, input t_result want);
        t_result pred;
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_user <= op;
        s_data <= {4'h0, pins, b};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        pred = lcd_bus_after_tick(op, b, pins);
        bus_levels_q.push_back(has_want ? want : pred);
        @(negedge clk);
    endtask

    task automatic run_to_idle();
        while (ph != PH_IDLE) begin
            send_tick(OP_TICK, 8'($urandom_range(255)), 4'($urandom_range(15)), 1'b0, '0);
        end
    endtask

    task automatic wait_results_done();
        s_valid <= 1'b0;
        while (bus_levels_q.size() != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        shadow_reg_write(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    always @(posedge clk) begin
        t_result got;
        t_result want;
        if (rst_n && m_valid && m_ready) begin
            if (bus_levels_q.size() == 0) begin
                report_mismatch("unexpected result transaction", 32'(m_data), 32'd0);
            end else begin
                want = bus_levels_q.pop_front();
                got = t_result'(m_data[17:0]);
                if (got.reg_select !== want.reg_select)
                    report_mismatch("reg_select", 32'(got.reg_select),
                                    32'(want.reg_select));
                if (got.read_write !== want.read_write)
                    report_mismatch("read_write", 32'(got.read_write),
                                    32'(want.read_write));
                if (got.enable_line !== want.enable_line)
                    report_mismatch("enable_line", 32'(got.enable_line),
                                    32'(want.enable_line));
                if (got.nibble_out !== want.nibble_out)
                    report_mismatch("nibble_out", 32'(got.nibble_out),
                                    32'(want.nibble_out));
                if (got.drive_pins !== want.drive_pins)
                    report_mismatch("drive_pins", 32'(got.drive_pins),
                                    32'(want.drive_pins));
                if (got.ready_res !== want.ready_res)
                    report_mismatch("ready_res", 32'(got.ready_res),
                                    32'(want.ready_res));
                if (got.rejected !== want.rejected)
                    report_mismatch("rejected", 32'(got.rejected),
                                    32'(want.rejected));
                if (got.status_byte !== want.status_byte)
                    report_mismatch("status_byte", 32'(got.status_byte),
                                    32'(want.status_byte));
            end
        end
    end

    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        int         roll;
        int         taken;
        logic [1:0] op;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_REG) begin
                wait_results_done();
                write_reg(dir_tab[i].idx, dir_tab[i].val);
            end else begin
                send_tick(dir_tab[i].op, dir_tab[i].val[7:0], dir_tab[i].pins,
                          dir_tab[i].has_want, dir_tab[i].want);
                if (dir_tab[i].run_out) run_to_idle();
            end
        end

        for (int stage = 0; stage < 3; stage++) begin
            if (stage == 1) begin
                src_idle = 82;
                dst_idle = 27;
            end else if (stage == 2) begin
                src_idle = 0;
                dst_idle = 0;
            end
            wait_results_done();
            write_reg(CFG_USE_BUSY, CFG_DATA_W'($urandom_range(1)));
            write_reg(CFG_STROBE, CFG_DATA_W'($urandom_range(3)));
            write_reg(CFG_SETTLE, CFG_DATA_W'($urandom_range(12)));
            write_reg(CFG_SHORT, CFG_DATA_W'($urandom_range(10)));
            write_reg(CFG_MODE, CFG_DATA_W'($urandom_range(8)));
            write_reg(CFG_POWER_UP, CFG_DATA_W'($urandom_range(16)));
            taken = 0;
            while (taken < 8) begin
                if (ph == PH_IDLE) begin
                    roll = $urandom_range(99);
                    if (roll < 45) op = OP_CMD;
                    else if (roll < 88) op = OP_DATA;
                    else if (roll < 94) op = OP_INIT;
                    else op = OP_TICK;
                    if (op != OP_TICK) taken++;
                end else begin
                    // requests while busy get rejected
                    op = ($urandom_range(99) < 12) ? 2'($urandom_range(3, 1)) : OP_TICK;
                end
                send_tick(op, 8'($urandom_range(255)), 4'($urandom_range(15)), 1'b0, '0);
            end
            run_to_idle();
        end

        wait_results_done();
        repeat (4) @(posedge clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/lcdnib_pkg.sv
hw/rtl/char_lcd_nibble_bus_sequencer.sv
tb/sv/tb_char_lcd_nibble_bus_sequencer.sv
